// File: hdl/lcd_nibble_writer_with_decimal_macros.svh
// assertion helpers used by the checker file
`ifndef LCD_NIBBLE_WRITER_WITH_DECIMAL_MACROS_SVH
`define LCD_NIBBLE_WRITER_WITH_DECIMAL_MACROS_SVH

// same-cycle implication, clocked on i_clk, off while in reset
`define LNWD_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off while in reset
`define LNWD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/lnwd_pkg.sv
`default_nettype none
package lnwd_pkg;

    // field widths
    localparam int BIN_W       = 16;
    localparam int DIG_W       = 4;
    localparam int BCD_DIGITS  = 5;
    localparam int BCD_W       = BCD_DIGITS * DIG_W;
    localparam int POS_W       = 4;
    localparam int MAX_NIBBLES = 2 * BCD_DIGITS;

    // double-dabble split: steps per stage times stages covers every input bit
    localparam int DD_STEPS  = 4;
    localparam int DD_STAGES = BIN_W / DD_STEPS;

    // command codes
    localparam logic [1:0] CMD_INSTR  = 2'd0;
    localparam logic [1:0] CMD_CHAR   = 2'd1;
    localparam logic [1:0] CMD_NUMBER = 2'd2;

    // ascii '0' is 0x30: high nibble fixed, low nibble is the digit
    localparam logic [7:0]       ASCII_ZERO    = 8'd48;
    localparam logic [DIG_W-1:0] ASCII_ZERO_HI = ASCII_ZERO[7:4];

    // item in the conversion pipeline
    typedef struct packed {
        logic             is_num;
        logic             rs;
        logic [BIN_W-1:0] bin;
        logic [BCD_W-1:0] bcd;
    } t_work;

    // item ready for the nibble emitter
    typedef struct packed {
        logic                             rs;
        logic [DIG_W-1:0]                 hi;
        logic [BCD_DIGITS-1:0][DIG_W-1:0] digits;
        logic [POS_W-1:0]                 last_pos;
    } t_load;

endpackage
`default_nettype wire

// File: hdl/lnwd_dd_stage.sv
`default_nettype none
module lnwd_dd_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  lnwd_pkg::t_work i_work,
    output logic           o_valid,
    input  logic           i_ready,
    output lnwd_pkg::t_work o_work
);

    localparam int SH_W = lnwd_pkg::BCD_W + lnwd_pkg::BIN_W;

    logic            r_valid;
    lnwd_pkg::t_work r_work;

    // DD_STEPS shift-and-add-3 steps; byte items pass through untouched
    function automatic lnwd_pkg::t_work dd_steps(input lnwd_pkg::t_work w);
        lnwd_pkg::t_work              res;
        logic [SH_W-1:0]              sh;
        logic [lnwd_pkg::DIG_W-1:0]   d;
        res = w;
        sh  = {w.bcd, w.bin};
        for (int s = 0; s < lnwd_pkg::DD_STEPS; s++) begin
            for (int k = 0; k < lnwd_pkg::BCD_DIGITS; k++) begin
                d = sh[lnwd_pkg::BIN_W + lnwd_pkg::DIG_W*k +: lnwd_pkg::DIG_W];
                if (d >= 4'd5) begin
                    sh[lnwd_pkg::BIN_W + lnwd_pkg::DIG_W*k +: lnwd_pkg::DIG_W] = d + 4'd3;
                end
            end
            sh = sh << 1;
        end
        if (w.is_num) begin
            res.bcd = sh[SH_W-1:lnwd_pkg::BIN_W];
            res.bin = sh[lnwd_pkg::BIN_W-1:0];
        end
        return res;
    endfunction

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_work  = r_work;

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_work <= dd_steps(i_work);
        end
    end

endmodule
`default_nettype wire

// File: hdl/lnwd_align.sv
`default_nettype none
module lnwd_align #(
    parameter int KEEP = 5
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  lnwd_pkg::t_work i_work,
    output logic            o_valid,
    input  logic            i_ready,
    output lnwd_pkg::t_load o_load
);

    localparam logic [2:0] KEEP_C = 3'(KEEP);

    logic            r_valid;
    lnwd_pkg::t_load r_load;
    lnwd_pkg::t_load w_load;

    logic [lnwd_pkg::BCD_DIGITS-1:0][lnwd_pkg::DIG_W-1:0] w_dig;
    logic [2:0] w_nd;
    logic [2:0] w_cnt;
    logic [2:0] w_idx;

    // count significant digits, keep the lowest ones, most significant first
    always_comb begin
        w_dig = i_work.bcd;
        w_nd  = 3'd0;
        for (int k = 0; k < lnwd_pkg::BCD_DIGITS; k++) begin
            if (w_dig[k] != '0) begin
                w_nd = 3'(k + 1);
            end
        end
        if (w_nd == 3'd0) begin
            w_nd = 3'd1;
        end
        w_cnt = (w_nd > KEEP_C) ? KEEP_C : w_nd;

        w_load.rs = i_work.rs;
        w_idx     = 3'd0;
        if (i_work.is_num) begin
            w_load.hi       = lnwd_pkg::ASCII_ZERO_HI;
            w_load.last_pos = 4'({w_cnt, 1'b0}) - 4'd1;
            w_load.digits   = '0;
            for (int j = 0; j < lnwd_pkg::BCD_DIGITS; j++) begin
                if (3'(j) < w_cnt) begin
                    w_idx = w_cnt - 3'd1 - 3'(j);
                    w_load.digits[j] = w_dig[w_idx];
                end
            end
        end else begin
            w_load.hi        = i_work.bin[7:4];
            w_load.last_pos  = 4'd1;
            w_load.digits    = '0;
            w_load.digits[0] = i_work.bin[3:0];
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_load  = r_load;

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_load <= w_load;
        end
    end

endmodule
`default_nettype wire

// File: hdl/lnwd_emit.sv
`default_nettype none
module lnwd_emit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  lnwd_pkg::t_load           i_load,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic                      o_register_select,
    output logic [lnwd_pkg::DIG_W-1:0] o_nibble,
    output logic                      o_last
);

    logic                                                 r_busy;
    logic [lnwd_pkg::POS_W-1:0]                           r_pos;
    logic                                                 r_rs;
    logic [lnwd_pkg::DIG_W-1:0]                           r_hi;
    logic [lnwd_pkg::BCD_DIGITS-1:0][lnwd_pkg::DIG_W-1:0] r_digits;
    logic [lnwd_pkg::POS_W-1:0]                           r_last_pos;
    logic                                                 r_ovalid;
    logic                                                 r_orsel;
    logic [lnwd_pkg::DIG_W-1:0]                           r_onib;
    logic                                                 r_olast;

    logic w_adv;
    logic w_fin;
    logic w_take;

    // output slot free, current nibble is the item's final one
    assign w_adv   = !r_ovalid || i_ready;
    assign w_fin   = r_busy && (r_pos == r_last_pos);
    assign o_ready = !r_busy || (w_adv && w_fin);
    assign w_take  = i_valid && o_ready;

    assign o_valid           = r_ovalid;
    assign o_register_select = r_orsel;
    assign o_nibble          = r_onib;
    assign o_last            = r_olast;

    // control: busy flag, nibble position, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_pos    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_ovalid <= r_busy;
            end
            if (w_take) begin
                r_busy <= 1'b1;
                r_pos  <= '0;
            end else if (w_adv && r_busy) begin
                r_pos <= r_pos + 1'b1;
                if (w_fin) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // held item: digits shift out after each low nibble
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_rs       <= i_load.rs;
            r_hi       <= i_load.hi;
            r_digits   <= i_load.digits;
            r_last_pos <= i_load.last_pos;
        end else if (w_adv && r_busy && r_pos[0]) begin
            r_digits <= {{lnwd_pkg::DIG_W{1'b0}},
                         r_digits[lnwd_pkg::BCD_DIGITS-1:1]};
        end
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if (w_adv && r_busy) begin
            r_orsel <= r_rs;
            r_onib  <= r_pos[0] ? r_digits[0] : r_hi;
            r_olast <= w_fin;
        end
    end

endmodule
`default_nettype wire

// File: hdl/lcd_nibble_writer_with_decimal.sv
// an input beat runs through the double-dabble stages, align, emitter item and output registers
// throughput: one nibble per clock with i_ready high; a byte is 2 nibbles, a number 2 per digit
// (up to 10); the nibble emitter sets the sustained rate, the 5-stage front takes a beat a clock
// when not held by the emitter; the unused command code is taken and dropped with no output
// reset: synchronous, active low; clears all valid bits, data registers are not reset
`default_nettype none
module lcd_nibble_writer_with_decimal #(
    parameter int MAX_DIGITS = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_command,
    input  logic [15:0] i_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_register_select,
    output logic [3:0]  o_nibble,
    output logic        o_last
);

    localparam int KEEP = (MAX_DIGITS < lnwd_pkg::BCD_DIGITS) ? MAX_DIGITS
                                                              : lnwd_pkg::BCD_DIGITS;

    logic            w_valid [0:lnwd_pkg::DD_STAGES];
    logic            w_ready [0:lnwd_pkg::DD_STAGES];
    lnwd_pkg::t_work w_work  [0:lnwd_pkg::DD_STAGES];

    logic            w_al_valid;
    logic            w_al_ready;
    lnwd_pkg::t_load w_al_load;

    // input beat into the pipeline; unused command code gets no valid bit
    assign w_valid[0]       = i_valid && (i_command == lnwd_pkg::CMD_INSTR
                                          || i_command == lnwd_pkg::CMD_CHAR
                                          || i_command == lnwd_pkg::CMD_NUMBER);
    assign o_ready          = w_ready[0];
    assign w_work[0].is_num = (i_command == lnwd_pkg::CMD_NUMBER);
    assign w_work[0].rs     = (i_command != lnwd_pkg::CMD_INSTR);
    assign w_work[0].bin    = i_value;
    assign w_work[0].bcd    = '0;

    // binary to bcd stages
    for (genvar g = 0; g < lnwd_pkg::DD_STAGES; g++) begin : g_dd
        lnwd_dd_stage u_dd (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_work  (w_work[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_work  (w_work[g+1])
        );
    end

    // digit count and ordering
    lnwd_align #(
        .KEEP (KEEP)
    ) u_align (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[lnwd_pkg::DD_STAGES]),
        .o_ready (w_ready[lnwd_pkg::DD_STAGES]),
        .i_work  (w_work[lnwd_pkg::DD_STAGES]),
        .o_valid (w_al_valid),
        .i_ready (w_al_ready),
        .o_load  (w_al_load)
    );

    // nibble serializer
    lnwd_emit u_emit (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (w_al_valid),
        .o_ready           (w_al_ready),
        .i_load            (w_al_load),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_register_select (o_register_select),
        .o_nibble          (o_nibble),
        .o_last            (o_last)
    );

endmodule
`default_nettype wire

// File: hdl/lnwd_chk.sv
`default_nettype none
`include "lcd_nibble_writer_with_decimal_macros.svh"
module lnwd_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic       o_register_select,
    input logic [3:0] o_nibble,
    input logic       o_last
);

    logic [lnwd_pkg::POS_W-1:0] r_cnt;
    logic                       r_rs;

    // nibbles seen so far in the current item and their register select
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rs  <= 1'b0;
        end else if (o_valid && i_ready) begin
            r_cnt <= o_last ? '0 : r_cnt + 1'b1;
            r_rs  <= o_register_select;
        end
    end

    // stalled beat holds
    `LNWD_ASSERT_NEXT(a_stall_hold, o_valid && !i_ready, o_valid && $stable(o_nibble) && $stable(o_register_select) && $stable(o_last), "stalled output beat changed")
    // one register select per item
    `LNWD_ASSERT(a_rs_steady, o_valid && r_cnt != '0, o_register_select == r_rs, "register select changed inside an item")
    // every item has at least one byte
    `LNWD_ASSERT(a_first_not_last, o_valid && r_cnt == '0, !o_last, "item ended after one nibble")
    // items end on a low nibble
    `LNWD_ASSERT(a_last_low, o_valid && o_last, r_cnt[0], "item ended on a high nibble")
    // no item is longer than five digits
    `LNWD_ASSERT(a_bounded, o_valid, r_cnt < 4'(lnwd_pkg::MAX_NIBBLES), "item too long")

endmodule

bind lcd_nibble_writer_with_decimal lnwd_chk u_lnwd_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_valid           (o_valid),
    .i_ready           (i_ready),
    .o_register_select (o_register_select),
    .o_nibble          (o_nibble),
    .o_last            (o_last)
);
`default_nettype wire
